// ----- hw/rtl/bhcs_pkg.sv -----
`timescale 1ns / 1ps

package bhcs_pkg;

   // widths fixed by the register and result formats
   localparam int CFG_BITS       = 4;
   localparam int CSR_INDEX_BITS = 2;
   localparam int GUN_MODE_BITS  = 2;

   // configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_HOLD_NORMAL      = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_HOLD_CALIBRATING = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SOLENOID_FRAMES  = 2'd2;

   // configuration reset values
   localparam logic [CFG_BITS-1:0] HOLD_NORMAL_RESET      = 4'd1;
   localparam logic [CFG_BITS-1:0] HOLD_CALIBRATING_RESET = 4'd5;
   localparam logic [CFG_BITS-1:0] SOLENOID_FRAMES_RESET  = 4'd2;

   // gun mode codes as reported on the result channel
   localparam logic [GUN_MODE_BITS-1:0] GUN_NORMAL    = 2'd0;
   localparam logic [GUN_MODE_BITS-1:0] GUN_TOP_LEFT  = 2'd1;
   localparam logic [GUN_MODE_BITS-1:0] GUN_LOW_RIGHT = 2'd2;

   // gun mode state machine
   typedef enum logic [2:0] {
      MODE_NORMAL    = 3'b001,
      MODE_TOP_LEFT  = 3'b010,
      MODE_LOW_RIGHT = 3'b100
   } mode_type;

endpackage

// ----- hw/rtl/bhcs_if.sv -----
`timescale 1ns / 1ps

// frame transaction: button edges, pin levels and aim point
interface bhcs_req_if #(
   parameter int NUM_BUTTONS = 8,
   parameter int AIM_BITS    = 16
);
   logic                   valid;
   logic                   ready;
   logic [NUM_BUTTONS-1:0] edge_flags;
   logic [NUM_BUTTONS-1:0] pin_levels;
   logic [AIM_BITS-1:0]    aim_x;
   logic [AIM_BITS-1:0]    aim_y;

   modport source (output valid, output edge_flags, output pin_levels,
                   output aim_x, output aim_y, input ready);
   modport sink   (input valid, input edge_flags, input pin_levels,
                   input aim_x, input aim_y, output ready);
endinterface

// result transaction: button state, gun mode and calibration corners
interface bhcs_rsp_if #(
   parameter int NUM_BUTTONS = 8,
   parameter int AIM_BITS    = 16
);
   logic                                 valid;
   logic                                 ready;
   logic [NUM_BUTTONS-1:0]               button_report;
   logic [NUM_BUTTONS-1:0]               new_press;
   logic [bhcs_pkg::GUN_MODE_BITS-1:0]   gun_mode;
   logic                                 solenoid_drive;
   logic                                 calibration_led;
   logic                                 calibration_done;
   logic [AIM_BITS-1:0]                  top_left_x;
   logic [AIM_BITS-1:0]                  top_left_y;
   logic [AIM_BITS-1:0]                  low_right_x;
   logic [AIM_BITS-1:0]                  low_right_y;

   modport source (output valid, output button_report, output new_press,
                   output gun_mode, output solenoid_drive, output calibration_led,
                   output calibration_done, output top_left_x, output top_left_y,
                   output low_right_x, output low_right_y, input ready);
   modport sink   (input valid, input button_report, input new_press,
                   input gun_mode, input solenoid_drive, input calibration_led,
                   input calibration_done, input top_left_x, input top_left_y,
                   input low_right_x, input low_right_y, output ready);
endinterface

// ----- hw/rtl/bhcs_buttons.sv -----
`timescale 1ns / 1ps

module bhcs_buttons #(
   parameter int NUM_BUTTONS = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             update,
   input  logic [NUM_BUTTONS-1:0]           edges,
   input  logic [NUM_BUTTONS-1:0]           levels,
   input  logic [bhcs_pkg::CFG_BITS-1:0]    hold_len,
   output logic [NUM_BUTTONS-1:0]           pressed,
   output logic [NUM_BUTTONS-1:0]           fresh
);
   import bhcs_pkg::*;

   logic [CFG_BITS-1:0]    count_ff [NUM_BUTTONS];
   logic [CFG_BITS-1:0]    count_in [NUM_BUTTONS];
   logic [NUM_BUTTONS-1:0] pressed_ff;
   logic [NUM_BUTTONS-1:0] pressed_in;

   // per-button press, hold countdown and release
   always_comb begin
      pressed_in = pressed_ff;
      fresh      = '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         count_in[i] = count_ff[i];
         if (edges[i] && (count_ff[i] == '0)) begin
            count_in[i]   = hold_len;
            pressed_in[i] = 1'b1;
            fresh[i]      = 1'b1;
         end else if (pressed_ff[i]) begin
            if (count_ff[i] == '0) begin
               if (levels[i]) begin
                  pressed_in[i] = 1'b0;
               end
            end else begin
               count_in[i] = count_ff[i] - 1'b1;
            end
         end
      end
   end

   // state moves once per frame transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         pressed_ff <= '0;
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            count_ff[i] <= '0;
         end
      end else if (update) begin
         pressed_ff <= pressed_in;
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            count_ff[i] <= count_in[i];
         end
      end
   end

   assign pressed = pressed_ff;

endmodule

// ----- hw/rtl/button_hold_calibration_solenoid.sv -----
`timescale 1ns / 1ps
// path: an accepted frame transaction waits in the input register until the result
//   register is free; its result is valid once it reaches the result register
// throughput: one frame transaction per cycle when not stalled, set by the single
//   pass from input register through button and mode logic into the result register
// reset: synchronous active-high; clears buttons, mode, solenoid, registers to
//   their defaults and corners to top-left zero and bottom-right all ones
module button_hold_calibration_solenoid #(
   parameter int NUM_BUTTONS = 8,
   parameter int AIM_BITS    = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   bhcs_req_if.sink                               req,
   bhcs_rsp_if.source                             rsp,
   input  logic                                   csr_write_enable,
   input  logic [bhcs_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [bhcs_pkg::CFG_BITS-1:0]          csr_write_data
);
   import bhcs_pkg::*;

   localparam int TRIGGER_BTN = 0;
   localparam int CAL_BTN     = NUM_BUTTONS - 1;

   // configuration registers
   logic [CFG_BITS-1:0] hold_normal_ff;
   logic [CFG_BITS-1:0] hold_cal_ff;
   logic [CFG_BITS-1:0] sol_frames_ff;

   // input stage
   logic                   s1_valid_ff;
   logic [NUM_BUTTONS-1:0] s1_edges_ff;
   logic [NUM_BUTTONS-1:0] s1_levels_ff;
   logic [AIM_BITS-1:0]    s1_aim_x_ff;
   logic [AIM_BITS-1:0]    s1_aim_y_ff;

   // frame state
   mode_type            mode_ff, mode_in;
   logic [CFG_BITS-1:0] sol_count_ff, sol_count_in;
   logic                sol_on_ff, sol_on_in;
   logic [AIM_BITS-1:0] tl_x_ff, tl_x_in, tl_y_ff, tl_y_in;
   logic [AIM_BITS-1:0] br_x_ff, br_x_in, br_y_ff, br_y_in;

   // result stage
   logic                   rsp_valid_ff;
   logic [NUM_BUTTONS-1:0] new_press_ff;
   logic                   done_ff, done_in;

   logic                   advance;
   logic                   fire;
   logic [CFG_BITS-1:0]    hold_len;
   logic [NUM_BUTTONS-1:0] pressed;
   logic [NUM_BUTTONS-1:0] fresh;

   // handshake: result register frees when taken
   assign advance   = !rsp_valid_ff || rsp.ready;
   assign fire      = s1_valid_ff && advance;
   assign req.ready = !s1_valid_ff || advance;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_normal_ff <= HOLD_NORMAL_RESET;
         hold_cal_ff    <= HOLD_CALIBRATING_RESET;
         sol_frames_ff  <= SOLENOID_FRAMES_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_HOLD_NORMAL:      hold_normal_ff <= csr_write_data;
            REG_HOLD_CALIBRATING: hold_cal_ff    <= csr_write_data;
            REG_SOLENOID_FRAMES:  sol_frames_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req.ready) begin
         s1_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         s1_edges_ff  <= req.edge_flags;
         s1_levels_ff <= req.pin_levels;
         s1_aim_x_ff  <= req.aim_x;
         s1_aim_y_ff  <= req.aim_y;
      end
   end

   // hold length follows the mode
   assign hold_len = (mode_ff == MODE_NORMAL) ? hold_normal_ff : hold_cal_ff;

   bhcs_buttons #(
      .NUM_BUTTONS (NUM_BUTTONS)
   ) u_buttons (
      .clock    (clock),
      .reset    (reset),
      .update   (fire),
      .edges    (s1_edges_ff),
      .levels   (s1_levels_ff),
      .hold_len (hold_len),
      .pressed  (pressed),
      .fresh    (fresh)
   );

   // calibrate and trigger actions, then the solenoid countdown
   always_comb begin
      mode_in      = mode_ff;
      sol_count_in = sol_count_ff;
      sol_on_in    = sol_on_ff;
      tl_x_in      = tl_x_ff;
      tl_y_in      = tl_y_ff;
      br_x_in      = br_x_ff;
      br_y_in      = br_y_ff;
      done_in      = 1'b0;
      if (fresh[CAL_BTN]) begin
         mode_in = MODE_TOP_LEFT;
      end else if (fresh[TRIGGER_BTN]) begin
         unique case (mode_ff)
            MODE_TOP_LEFT: begin
               tl_x_in = s1_aim_x_ff;
               tl_y_in = s1_aim_y_ff;
               mode_in = MODE_LOW_RIGHT;
            end
            MODE_LOW_RIGHT: begin
               br_x_in = s1_aim_x_ff;
               br_y_in = s1_aim_y_ff;
               mode_in = MODE_NORMAL;
               done_in = 1'b1;
            end
            MODE_NORMAL: begin
               if (sol_count_ff == '0) begin
                  sol_count_in = sol_frames_ff;
                  sol_on_in    = 1'b1;
               end
            end
            default: ;
         endcase
      end
      if (sol_count_in == '0) begin
         sol_on_in = 1'b0;
      end else begin
         sol_count_in = sol_count_in - 1'b1;
      end
   end

   // frame state, updated once per transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_NORMAL;
         sol_count_ff <= '0;
         sol_on_ff    <= 1'b0;
         tl_x_ff      <= '0;
         tl_y_ff      <= '0;
         br_x_ff      <= '1;
         br_y_ff      <= '1;
      end else if (fire) begin
         mode_ff      <= mode_in;
         sol_count_ff <= sol_count_in;
         sol_on_ff    <= sol_on_in;
         tl_x_ff      <= tl_x_in;
         tl_y_ff      <= tl_y_in;
         br_x_ff      <= br_x_in;
         br_y_ff      <= br_y_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         new_press_ff <= fresh;
         done_ff      <= done_in;
      end
   end

   // state registers double as result payload: they move only with a new result
   always_comb begin
      unique case (mode_ff)
         MODE_TOP_LEFT:  rsp.gun_mode = GUN_TOP_LEFT;
         MODE_LOW_RIGHT: rsp.gun_mode = GUN_LOW_RIGHT;
         default:        rsp.gun_mode = GUN_NORMAL;
      endcase
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.button_report    = pressed;
   assign rsp.new_press        = new_press_ff;
   assign rsp.solenoid_drive   = sol_on_ff;
   assign rsp.calibration_led  = (mode_ff != MODE_NORMAL);
   assign rsp.calibration_done = done_ff;
   assign rsp.top_left_x       = tl_x_ff;
   assign rsp.top_left_y       = tl_y_ff;
   assign rsp.low_right_x      = br_x_ff;
   assign rsp.low_right_y      = br_y_ff;

endmodule

// ----- tb/tb_button_hold_calibration_solenoid.sv -----
`timescale 1ns / 1ps

module tb_button_hold_calibration_solenoid;
   import bhcs_pkg::*;

   localparam int NUM_BUTTONS    = 8;
   localparam int AIM_BITS       = 16;
   localparam int TRIGGER_BUTTON = 0;
   localparam int CAL_BUTTON     = NUM_BUTTONS - 1;
   localparam int IDLE_LIMIT     = 2000;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int MAX_REPORTS    = 40;

   typedef logic [NUM_BUTTONS-1:0] btn_vec_type;
   typedef logic [AIM_BITS-1:0]    aim_type;

   typedef struct {
      btn_vec_type              button_report;
      btn_vec_type              new_press;
      logic [GUN_MODE_BITS-1:0] gun_mode;
      logic                     solenoid_drive;
      logic                     calibration_led;
      logic                     calibration_done;
      aim_type                  top_left_x;
      aim_type                  top_left_y;
      aim_type                  low_right_x;
      aim_type                  low_right_y;
   } frame_result_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_enable;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CFG_BITS-1:0] csr_write_data;

   bhcs_req_if #(.NUM_BUTTONS(NUM_BUTTONS), .AIM_BITS(AIM_BITS)) req_ch ();
   bhcs_rsp_if #(.NUM_BUTTONS(NUM_BUTTONS), .AIM_BITS(AIM_BITS)) rsp_ch ();

   button_hold_calibration_solenoid #(
      .NUM_BUTTONS(NUM_BUTTONS),
      .AIM_BITS(AIM_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   // clock generation
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow copy of the block's registers and state
   logic [CFG_BITS-1:0]      hold_normal_cfg = HOLD_NORMAL_RESET;
   logic [CFG_BITS-1:0]      hold_cal_cfg    = HOLD_CALIBRATING_RESET;
   logic [CFG_BITS-1:0]      solenoid_cfg    = SOLENOID_FRAMES_RESET;
   logic [CFG_BITS-1:0]      hold_cnt_q [NUM_BUTTONS] = '{default: '0};
   btn_vec_type              pressed_q   = '0;
   logic [GUN_MODE_BITS-1:0] gun_mode_q  = GUN_NORMAL;
   logic [CFG_BITS-1:0]      sol_count_q = '0;
   logic                     sol_on_q    = 1'b0;
   aim_type                  corner_tl_x = '0;
   aim_type                  corner_tl_y = '0;
   aim_type                  corner_br_x = '1;
   aim_type                  corner_br_y = '1;

   frame_result_type expected_frames [$];

   int frames_sent       = 0;
   int frames_checked    = 0;
   int mismatch_count    = 0;
   int presses_seen      = 0;
   int shots_fired       = 0;
   int calibrations_done = 0;
   int burst_left        = 0;
   bit no_gaps           = 1'b0;
   bit hold_off_request  = 1'b0;

   // next frame result from the shadow state, updating it
   function automatic frame_result_type predict_frame(input btn_vec_type edges,
                                                      input btn_vec_type levels,
                                                      input aim_type ax, input aim_type ay);
      logic [CFG_BITS-1:0] hold_len;
      btn_vec_type         held_before;
      btn_vec_type         fresh;
      logic                done;
      frame_result_type    r;
      hold_len    = (gun_mode_q != GUN_NORMAL) ? hold_cal_cfg : hold_normal_cfg;
      held_before = pressed_q;
      fresh       = '0;
      done        = 1'b0;

      // per-button press, hold countdown and release
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         if (edges[i] && hold_cnt_q[i] == '0) begin
            hold_cnt_q[i] = hold_len;
            pressed_q[i]  = 1'b1;
            fresh[i]      = 1'b1;
         end else if (held_before[i]) begin
            if (hold_cnt_q[i] == '0) begin
               if (levels[i]) pressed_q[i] = 1'b0;
            end else begin
               hold_cnt_q[i] = hold_cnt_q[i] - 1'b1;
            end
         end
      end
      presses_seen += $countones(fresh);

      // calibrate wins over trigger
      if (fresh[CAL_BUTTON]) begin
         gun_mode_q = GUN_TOP_LEFT;
      end else if (fresh[TRIGGER_BUTTON]) begin
         case (gun_mode_q)
            GUN_TOP_LEFT: begin
               corner_tl_x = ax;
               corner_tl_y = ay;
               gun_mode_q  = GUN_LOW_RIGHT;
            end
            GUN_LOW_RIGHT: begin
               corner_br_x = ax;
               corner_br_y = ay;
               gun_mode_q  = GUN_NORMAL;
               done        = 1'b1;
               calibrations_done++;
            end
            GUN_NORMAL: begin
               if (sol_count_q == '0) begin
                  sol_count_q = solenoid_cfg;
                  sol_on_q    = 1'b1;
                  shots_fired++;
               end
            end
            default: ;
         endcase
      end

      // solenoid countdown
      if (sol_count_q == '0) sol_on_q = 1'b0;
      else sol_count_q = sol_count_q - 1'b1;

      r.button_report    = pressed_q;
      r.new_press        = fresh;
      r.gun_mode         = gun_mode_q;
      r.solenoid_drive   = sol_on_q;
      r.calibration_led  = (gun_mode_q != GUN_NORMAL);
      r.calibration_done = done;
      r.top_left_x       = corner_tl_x;
      r.top_left_y       = corner_tl_y;
      r.low_right_x      = corner_br_x;
      r.low_right_y      = corner_br_y;
      return r;
   endfunction

   function automatic aim_type pick_aim();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return aim_type'($urandom);
      endcase
   endfunction

   // send one frame transaction, with bursts and gaps
   task automatic send_frame(input btn_vec_type edges, input btn_vec_type levels,
                             input aim_type ax, input aim_type ay);
      int gap;
      if (!no_gaps && burst_left == 0) begin
         gap = $urandom_range(1, 6);
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
         burst_left = $urandom_range(1, 20);
      end
      @(negedge clock);
      req_ch.valid      <= 1'b1;
      req_ch.edge_flags <= edges;
      req_ch.pin_levels <= levels;
      req_ch.aim_x      <= ax;
      req_ch.aim_y      <= ay;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expected_frames.push_back(predict_frame(edges, levels, ax, ay));
      frames_sent++;
      if (burst_left > 0) burst_left--;
   endtask

   task automatic send_quiet(input int count);
      repeat (count) send_frame('0, '1, pick_aim(), pick_aim());
   endtask

   // drop valid and wait for every outstanding result
   task automatic drain_results();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      burst_left = 0;
      while (expected_frames.size() != 0) @(posedge clock);
   endtask

   // write all three registers while the block is idle
   task automatic configure(input logic [CFG_BITS-1:0] hold_normal,
                            input logic [CFG_BITS-1:0] hold_cal,
                            input logic [CFG_BITS-1:0] sol_frames);
      drain_results();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= REG_HOLD_NORMAL;
      csr_write_data   <= hold_normal;
      @(negedge clock);
      csr_index        <= REG_HOLD_CALIBRATING;
      csr_write_data   <= hold_cal;
      @(negedge clock);
      csr_index        <= REG_SOLENOID_FRAMES;
      csr_write_data   <= sol_frames;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      hold_normal_cfg = hold_normal;
      hold_cal_cfg    = hold_cal;
      solenoid_cfg    = sol_frames;
   endtask

   // reset values of the corners and an all-released frame
   task automatic test_idle_defaults();
      send_frame('0, '0, '0, '0);
      send_frame('0, '1, '1, '1);
   endtask

   // press, edge while held, hold on low pin, release on high pin
   task automatic test_press_release();
      send_frame(8'h7E, '0, 16'h0001, 16'h8000);
      send_frame(8'h7E, '0, 16'h8000, 16'h0001);
      send_frame('0, '0, '1, '0);
      send_frame('0, '1, '0, '1);
      send_frame(8'h7E, 8'h55, 16'hAAAA, 16'h5555);
   endtask

   // calibrate with trigger, then both corners, one trigger while held
   task automatic test_calibration();
      send_frame(8'h81, '1, 16'h1234, 16'h5678);
      send_quiet(2);
      send_frame(8'h01, '1, '1, '0);
      send_frame(8'h01, '0, 16'h4321, 16'h8765);
      send_quiet(5);
      send_frame(8'h01, '1, '0, '1);
   endtask

   // shot, shot while busy with zero hold, zero-length shot
   task automatic test_solenoid();
      send_quiet(5);
      configure(4'd0, 4'd5, 4'd2);
      send_frame(8'h01, '0, '0, '0);
      send_frame(8'h01, '0, '0, '0);
      send_quiet(1);
      configure(4'd0, 4'd0, 4'd0);
      send_frame(8'h01, '1, '0, '0);
      configure(4'd15, 4'd15, 4'd15);
      send_frame('1, '0, '1, '1);
   endtask

   // mostly plausible play, some calibration runs, some noise
   task automatic test_random_frames(input int count);
      int          target;
      btn_vec_type edges;
      btn_vec_type levels;
      target = frames_sent + count;
      while (frames_sent < target) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               send_frame(btn_vec_type'($urandom), btn_vec_type'($urandom),
                          aim_type'($urandom), aim_type'($urandom));
            end
            9: begin
               send_frame(btn_vec_type'(1) << CAL_BUTTON, '1, pick_aim(), pick_aim());
               send_quiet($urandom_range(0, hold_cal_cfg + 2));
               send_frame(btn_vec_type'(1) << TRIGGER_BUTTON, '1, pick_aim(), pick_aim());
               send_quiet($urandom_range(0, hold_cal_cfg + 2));
               send_frame(btn_vec_type'(1) << TRIGGER_BUTTON, '1, pick_aim(), pick_aim());
            end
            default: begin
               for (int i = 0; i < NUM_BUTTONS; i++) begin
                  edges[i]  = (i == CAL_BUTTON) ? ($urandom_range(0, 29) == 0)
                                                : ($urandom_range(0, 7) == 0);
                  levels[i] = ($urandom_range(0, 3) != 0);
               end
               send_frame(edges, levels, pick_aim(), pick_aim());
            end
         endcase
      end
   endtask

   // receiver holds off while frames keep coming, so the input stalls
   task automatic test_input_backpressure();
      hold_off_request = 1'b1;
      no_gaps = 1'b1;
      test_random_frames(40);
      no_gaps = 1'b0;
   endtask

   // receiver: stall pattern of its own, plus long hold-off on request
   initial begin
      int         hold_off_left;
      int         pattern_left;
      int         stall_style;
      logic [15:0] stall_bits;
      hold_off_left = 0;
      pattern_left  = 0;
      stall_style   = 0;
      stall_bits    = '1;
      rsp_ch.ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_off_left    = HOLD_OFF_CYCLES;
            hold_off_request = 1'b0;
         end
         if (hold_off_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_off_left--;
         end else begin
            if (pattern_left == 0) begin
               stall_style  = $urandom_range(0, 3);
               pattern_left = $urandom_range(20, 100);
               stall_bits   = 16'($urandom) | 16'h0001;
            end
            pattern_left--;
            case (stall_style)
               0: rsp_ch.ready <= 1'b1;
               1: begin
                  rsp_ch.ready <= stall_bits[0];
                  stall_bits = {stall_bits[0], stall_bits[15:1]};
               end
               2: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
               default: rsp_ch.ready <= ($urandom_range(0, 1) != 0);
            endcase
         end
      end
   end

   task automatic check_field(input string name, input aim_type want, input aim_type got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("%0t ns: %s expected %h actual %h", $time, name, want, got);
      end
   endtask

   // compare each result transaction with the oldest expected frame
   always @(posedge clock) begin
      frame_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         frames_checked++;
         if (expected_frames.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t ns: result with no frame outstanding, expected none actual %h",
                        $time, rsp_ch.button_report);
         end else begin
            want = expected_frames.pop_front();
            check_field("button_report", want.button_report, rsp_ch.button_report);
            check_field("new_press", want.new_press, rsp_ch.new_press);
            check_field("gun_mode", want.gun_mode, rsp_ch.gun_mode);
            check_field("solenoid_drive", want.solenoid_drive, rsp_ch.solenoid_drive);
            check_field("calibration_led", want.calibration_led, rsp_ch.calibration_led);
            check_field("calibration_done", want.calibration_done, rsp_ch.calibration_done);
            check_field("top_left_x", want.top_left_x, rsp_ch.top_left_x);
            check_field("top_left_y", want.top_left_y, rsp_ch.top_left_y);
            check_field("low_right_x", want.low_right_x, rsp_ch.low_right_x);
            check_field("low_right_y", want.low_right_y, rsp_ch.low_right_y);
         end
      end
   end

   // watchdog on cycles without any transaction
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d idle cycles, %0d results outstanding",
                     idle_cycles, expected_frames.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // test sequence
   initial begin
      reset             = 1'b1;
      csr_write_enable  = 1'b0;
      csr_index         = REG_HOLD_NORMAL;
      csr_write_data    = '0;
      req_ch.valid      = 1'b0;
      req_ch.edge_flags = '0;
      req_ch.pin_levels = '0;
      req_ch.aim_x      = '0;
      req_ch.aim_y      = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_idle_defaults();
      test_press_release();
      test_calibration();
      test_solenoid();

      configure(4'd2, 4'd5, 4'd3);
      test_random_frames(120);
      test_input_backpressure();
      configure(4'd0, 4'd15, 4'd1);
      test_random_frames(120);
      configure(4'd15, 4'd0, 4'd15);
      test_random_frames(120);
      configure(CFG_BITS'($urandom), CFG_BITS'($urandom), CFG_BITS'($urandom));
      test_random_frames(120);

      // let the last results come out
      drain_results();
      repeat (4) @(posedge clock);

      $display("%0d frames sent, %0d results checked, %0d mismatches",
               frames_sent, frames_checked, mismatch_count);
      $display("%0d button presses, %0d solenoid shots, %0d calibrations completed",
               presses_seen, shots_fired, calibrations_done);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
